>>> src/particle_state_update_unit_assert.svh
// Assertion macros shared by the particle update checker.
`ifndef PARTICLE_STATE_UPDATE_UNIT_ASSERT_SVH
`define PARTICLE_STATE_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PSU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("particle update assertion failed");

// Next-cycle implication, checked out of reset.
`define PSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("particle update assertion failed");

`endif

>>> src/psu_pkg.sv
// Shared types and constants for the particle state update pipeline.
`timescale 1ns / 1ps
package psu_pkg;

  localparam int DivSteps = 16;
  localparam int PipeLatency = DivSteps + 4;
  localparam logic [16:0] AlphaOne = 17'h10000;
  localparam logic [30:0] AgeMax = 31'h7fffffff;

  localparam int IdxW = 3;
  localparam logic [IdxW-1:0] REG_ENABLES = 3'd0;
  localparam logic [IdxW-1:0] REG_SCALE_LOW_X = 3'd1;
  localparam logic [IdxW-1:0] REG_SCALE_LOW_Y = 3'd2;
  localparam logic [IdxW-1:0] REG_SCALE_HIGH_X = 3'd3;
  localparam logic [IdxW-1:0] REG_SCALE_HIGH_Y = 3'd4;
  localparam logic [IdxW-1:0] REG_TINT_LOW = 3'd5;
  localparam logic [IdxW-1:0] REG_TINT_HIGH = 3'd6;

  localparam int EN_TRANSLATE = 0;
  localparam int EN_ROTATE = 1;
  localparam int EN_SCALE = 2;
  localparam int EN_TINT = 3;

  // Fields that ride alongside the divider
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] rot;
    logic [30:0] age;
    logic        expired;
  } psu_side_t;

  // One divider stage worth of state
  typedef struct packed {
    logic        valid;
    logic [31:0] rem;
    logic [30:0] life;
    logic [15:0] quo;
    logic        full;
    psu_side_t   side;
  } psu_div_t;

  typedef struct packed {
    logic [3:0]  enables;
    logic [31:0] scale_low_x;
    logic [31:0] scale_low_y;
    logic [31:0] scale_high_x;
    logic [31:0] scale_high_y;
    logic [31:0] tint_low;
    logic [31:0] tint_high;
  } psu_cfg_t;

endpackage

>>> src/psu_div_stage.sv
// One restoring-division stage: produces one quotient bit of age/lifetime.
`timescale 1ns / 1ps
module psu_div_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  psu_pkg::psu_div_t d_i,
  output psu_pkg::psu_div_t d_r
);
  import psu_pkg::*;

  logic [31:0] shifted;
  logic        ge;
  psu_div_t    d_nxt;

  // Shift remainder, subtract divisor when it fits
  always_comb begin
    shifted = {d_i.rem[30:0], 1'b0};
    ge = (shifted >= {1'b0, d_i.life});
    d_nxt = d_i;
    d_nxt.rem = ge ? (shifted - {1'b0, d_i.life}) : shifted;
    d_nxt.quo = {d_i.quo[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else begin
      d_r.valid <= d_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    d_r.rem <= d_nxt.rem;
    d_r.life <= d_nxt.life;
    d_r.quo <= d_nxt.quo;
    d_r.full <= d_nxt.full;
    d_r.side <= d_nxt.side;
  end
endmodule

>>> src/psu_blend.sv
// Two-stage scale and tint blend: multiply by alpha, then floor and add.
`timescale 1ns / 1ps
module psu_blend (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [16:0]       alpha_i,
  input  psu_pkg::psu_side_t side_i,
  input  psu_pkg::psu_cfg_t  cfg_i,
  output logic              valid_r,
  output psu_pkg::psu_side_t side_r,
  output logic [31:0]       scale_x_r,
  output logic [31:0]       scale_y_r,
  output logic [31:0]       tint_r
);
  import psu_pkg::*;

  logic              va_r;
  psu_side_t         sa_r;
  logic signed [50:0] px_r, py_r;
  logic signed [26:0] pt_r [4];
  logic signed [32:0] dx, dy;
  logic signed [8:0]  dt [4];
  logic signed [17:0] alpha_s;
  logic [7:0]        lo_ch [4];
  logic [31:0]       sx_nxt, sy_nxt, tint_nxt;
  logic signed [33:0] sumx, sumy;
  logic signed [10:0] sumt [4];

  // Differences of high minus low
  always_comb begin
    alpha_s = $signed({1'b0, alpha_i});
    dx = $signed({cfg_i.scale_high_x[31], cfg_i.scale_high_x})
       - $signed({cfg_i.scale_low_x[31], cfg_i.scale_low_x});
    dy = $signed({cfg_i.scale_high_y[31], cfg_i.scale_high_y})
       - $signed({cfg_i.scale_low_y[31], cfg_i.scale_low_y});
    for (int c = 0; c < 4; c++) begin
      dt[c] = $signed({1'b0, cfg_i.tint_high[24-8*c +: 8]})
            - $signed({1'b0, cfg_i.tint_low[24-8*c +: 8]});
    end
  end

  // Stage A: products
  always_ff @(posedge clk) begin
    px_r <= dx * alpha_s;
    py_r <= dy * alpha_s;
    for (int c = 0; c < 4; c++) begin
      pt_r[c] <= dt[c] * alpha_s;
    end
    sa_r <= side_i;
  end

  // Stage B: floor shift and add to low value
  always_comb begin
    sumx = $signed({{2{cfg_i.scale_low_x[31]}}, cfg_i.scale_low_x}) + px_r[49:16];
    sumy = $signed({{2{cfg_i.scale_low_y[31]}}, cfg_i.scale_low_y}) + py_r[49:16];
    sx_nxt = cfg_i.enables[EN_SCALE] ? sumx[31:0] : cfg_i.scale_low_x;
    sy_nxt = cfg_i.enables[EN_SCALE] ? sumy[31:0] : cfg_i.scale_low_y;
    tint_nxt = cfg_i.tint_low;
    for (int c = 0; c < 4; c++) begin
      lo_ch[c] = cfg_i.tint_low[24-8*c +: 8];
      sumt[c] = $signed({3'b000, lo_ch[c]}) + pt_r[c][26:16];
      if (cfg_i.enables[EN_TINT]) begin
        tint_nxt[24-8*c +: 8] = sumt[c][7:0];
      end
    end
  end

  // Output registers
  always_ff @(posedge clk) begin
    side_r <= sa_r;
    scale_x_r <= sx_nxt;
    scale_y_r <= sy_nxt;
    tint_r <= tint_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      va_r <= valid_i;
      valid_r <= va_r;
    end
  end
endmodule

>>> src/particle_state_update_unit.sv
// Top level of the particle state update pipeline.
// Throughput: one particle per cycle.
// The alpha divider resolves one quotient bit per stage over 16 stages.
// busy stays low: a new request is taken every cycle, results cannot be stalled.
// Synchronous active-low reset clears all valid bits and restores config defaults.
`timescale 1ns / 1ps
module particle_state_update_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_rotation_deg,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_angular_vel,
  input  logic [30:0] in_age,
  input  logic [30:0] in_lifetime,
  input  logic [30:0] in_time_step,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [psu_pkg::IdxW-1:0] cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic [31:0] out_new_pos_x,
  output logic [31:0] out_new_pos_y,
  output logic [31:0] out_new_rotation,
  output logic [30:0] out_new_age,
  output logic [31:0] out_scale_x,
  output logic [31:0] out_scale_y,
  output logic [7:0]  out_tint_red,
  output logic [7:0]  out_tint_green,
  output logic [7:0]  out_tint_blue,
  output logic [7:0]  out_tint_alpha,
  output logic        out_expired
);
  import psu_pkg::*;

  psu_cfg_t cfg_r;

  logic        v0_r, v1_r;
  logic [31:0] pos_x0_r, pos_y0_r, rot0_r, vx0_r, vy0_r, va0_r;
  logic [30:0] age0_r, life0_r, step0_r;
  logic [31:0] age_sum;
  logic [30:0] new_age0;
  logic signed [63:0] prx_r, pry_r, prr_r;
  logic [31:0] pos_x1_r, pos_y1_r, rot1_r;
  logic [30:0] age1_r, life1_r;
  logic        exp1_r;

  psu_div_t div_bus [DivSteps+1];
  logic [16:0] alpha;
  logic        bl_valid;
  psu_side_t   bl_side;
  logic [31:0] bl_sx, bl_sy, bl_tint;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enables <= 4'hf;
      cfg_r.scale_low_x <= 32'h10000;
      cfg_r.scale_low_y <= 32'h10000;
      cfg_r.scale_high_x <= 32'h10000;
      cfg_r.scale_high_y <= 32'h10000;
      cfg_r.tint_low <= 32'hffffffff;
      cfg_r.tint_high <= 32'hffffffff;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLES:      cfg_r.enables <= cfg_wdata[3:0];
        REG_SCALE_LOW_X:  cfg_r.scale_low_x <= cfg_wdata;
        REG_SCALE_LOW_Y:  cfg_r.scale_low_y <= cfg_wdata;
        REG_SCALE_HIGH_X: cfg_r.scale_high_x <= cfg_wdata;
        REG_SCALE_HIGH_Y: cfg_r.scale_high_y <= cfg_wdata;
        REG_TINT_LOW:     cfg_r.tint_low <= cfg_wdata;
        REG_TINT_HIGH:    cfg_r.tint_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits for the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
    end
  end

  // Stage 0: capture request
  always_ff @(posedge clk) begin
    pos_x0_r <= in_pos_x;
    pos_y0_r <= in_pos_y;
    rot0_r <= in_rotation_deg;
    vx0_r <= in_vel_x;
    vy0_r <= in_vel_y;
    va0_r <= in_angular_vel;
    age0_r <= in_age;
    life0_r <= in_lifetime;
    step0_r <= in_time_step;
  end

  // Saturating age
  always_comb begin
    age_sum = {1'b0, age0_r} + {1'b0, step0_r};
    new_age0 = age_sum[31] ? AgeMax : age_sum[30:0];
  end

  // Stage 1: motion products, age and expiry
  always_ff @(posedge clk) begin
    prx_r <= $signed(vx0_r) * $signed({1'b0, step0_r});
    pry_r <= $signed(vy0_r) * $signed({1'b0, step0_r});
    prr_r <= $signed(va0_r) * $signed({1'b0, step0_r});
    pos_x1_r <= pos_x0_r;
    pos_y1_r <= pos_y0_r;
    rot1_r <= rot0_r;
    age1_r <= new_age0;
    life1_r <= life0_r;
    exp1_r <= (new_age0 >= life0_r);
  end

  // Divider input and motion sums
  always_comb begin
    div_bus[0].valid = v1_r;
    div_bus[0].rem = {1'b0, age1_r};
    div_bus[0].life = life1_r;
    div_bus[0].quo = '0;
    div_bus[0].full = exp1_r;
    div_bus[0].side.pos_x = cfg_r.enables[EN_TRANSLATE] ? pos_x1_r + prx_r[47:16] : pos_x1_r;
    div_bus[0].side.pos_y = cfg_r.enables[EN_TRANSLATE] ? pos_y1_r + pry_r[47:16] : pos_y1_r;
    div_bus[0].side.rot = cfg_r.enables[EN_ROTATE] ? rot1_r + prr_r[47:16] : rot1_r;
    div_bus[0].side.age = age1_r;
    div_bus[0].side.expired = exp1_r;
  end

  // Divider chain
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    psu_div_stage u_stage (
      .clk  (clk),
      .rst_n(rst_n),
      .d_i  (div_bus[k]),
      .d_r  (div_bus[k+1])
    );
  end

  assign alpha = div_bus[DivSteps].full ? AlphaOne : {1'b0, div_bus[DivSteps].quo};

  psu_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (div_bus[DivSteps].valid),
    .alpha_i  (alpha),
    .side_i   (div_bus[DivSteps].side),
    .cfg_i    (cfg_r),
    .valid_r  (bl_valid),
    .side_r   (bl_side),
    .scale_x_r(bl_sx),
    .scale_y_r(bl_sy),
    .tint_r   (bl_tint)
  );

  // Result ports
  assign out_valid = bl_valid;
  assign out_new_pos_x = bl_side.pos_x;
  assign out_new_pos_y = bl_side.pos_y;
  assign out_new_rotation = bl_side.rot;
  assign out_new_age = bl_side.age;
  assign out_expired = bl_side.expired;
  assign out_scale_x = bl_sx;
  assign out_scale_y = bl_sy;
  assign out_tint_red = bl_tint[31:24];
  assign out_tint_green = bl_tint[23:16];
  assign out_tint_blue = bl_tint[15:8];
  assign out_tint_alpha = bl_tint[7:0];
endmodule

>>> src/psu_checker.sv
// Port-level checker for the particle update unit, bound to the top level.
`timescale 1ns / 1ps
`include "particle_state_update_unit_assert.svh"
module psu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [30:0] in_lifetime,
  input logic        out_valid,
  input logic        out_expired
);
  import psu_pkg::*;

  `PSU_ASSERT_NEXT(a_never_busy, 1'b1, !busy)
  `PSU_ASSERT_IMPLY(a_no_spurious, out_valid, $past(start && !busy, PipeLatency))
  `PSU_ASSERT_IMPLY(a_no_drop, $past(start && !busy, PipeLatency) && $past(rst_n, PipeLatency), out_valid)
  `PSU_ASSERT_IMPLY(a_zero_life, out_valid && $past(start && in_lifetime == 31'd0, PipeLatency), out_expired)
endmodule

bind particle_state_update_unit psu_checker u_psu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_lifetime(in_lifetime),
  .out_valid  (out_valid),
  .out_expired(out_expired)
);

>>> test/tb_particle_state_update_unit.sv
// Self-checking testbench for the particle state update pipeline.
`timescale 1ns / 1ps
module tb_particle_state_update_unit;
  import psu_pkg::*;

  localparam logic [IdxW-1:0] REG_UNMAPPED = 3'd7;
  localparam int StallLimit = 4000;
  localparam int PhaseCount = 8;
  localparam int ItemsPerPhase = 160;

  typedef struct {
    logic [31:0] pos_x, pos_y, rot, vel_x, vel_y, ang;
    logic [30:0] age, life, step;
  } particle_t;

  typedef struct {
    logic [31:0] pos_x, pos_y, rot;
    logic [30:0] age;
    logic [31:0] scale_x, scale_y;
    logic [7:0]  red, green, blue, alpha;
    logic        expired;
  } update_t;

  // Holds a mirror of the config registers and the pending particle updates
  class particle_scoreboard;
    logic [3:0]  enables;
    logic [31:0] sc_lo_x, sc_lo_y, sc_hi_x, sc_hi_y, tint_lo, tint_hi;
    update_t     pending[$];
    int          errors;

    function void reset_regs();
      enables = 4'hf;
      sc_lo_x = 32'h10000; sc_lo_y = 32'h10000;
      sc_hi_x = 32'h10000; sc_hi_y = 32'h10000;
      tint_lo = '1; tint_hi = '1;
      errors = 0;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [31:0] val);
      case (idx)
        REG_ENABLES:      enables = val[3:0];
        REG_SCALE_LOW_X:  sc_lo_x = val;
        REG_SCALE_LOW_Y:  sc_lo_y = val;
        REG_SCALE_HIGH_X: sc_hi_x = val;
        REG_SCALE_HIGH_Y: sc_hi_y = val;
        REG_TINT_LOW:     tint_lo = val;
        REG_TINT_HIGH:    tint_hi = val;
        default: ;
      endcase
    endfunction

    // value + floor(rate * step / 2^16), wrapping
    function logic [31:0] integrate(logic [31:0] v, logic [31:0] rate, logic [30:0] step);
      longint p;
      p = longint'($signed(rate)) * longint'({33'b0, step});
      return v + p[47:16];
    endfunction

    function longint mix(longint lo, longint hi, longint a);
      longint d;
      d = (hi - lo) * a;
      return lo + (d >>> 16);
    endfunction

    function void note(particle_t p);
      update_t r;
      logic [31:0] sum;
      longint a;
      logic [63:0] q;
      logic [7:0] ch_lo, ch_hi;
      sum = {1'b0, p.age} + {1'b0, p.step};
      r.age = sum[31] ? AgeMax : sum[30:0];
      if (p.life == 0) begin
        a = 65536;
      end else begin
        q = {17'b0, r.age, 16'b0} / {33'b0, p.life};
        a = (q > 65536) ? 65536 : longint'(q);
      end
      r.pos_x = enables[EN_TRANSLATE] ? integrate(p.pos_x, p.vel_x, p.step) : p.pos_x;
      r.pos_y = enables[EN_TRANSLATE] ? integrate(p.pos_y, p.vel_y, p.step) : p.pos_y;
      r.rot = enables[EN_ROTATE] ? integrate(p.rot, p.ang, p.step) : p.rot;
      if (enables[EN_SCALE]) begin
        r.scale_x = 32'(mix($signed(sc_lo_x), $signed(sc_hi_x), a));
        r.scale_y = 32'(mix($signed(sc_lo_y), $signed(sc_hi_y), a));
      end else begin
        r.scale_x = sc_lo_x;
        r.scale_y = sc_lo_y;
      end
      for (int ch = 0; ch < 4; ch++) begin
        ch_lo = tint_lo[24 - 8 * ch +: 8];
        ch_hi = tint_hi[24 - 8 * ch +: 8];
        if (enables[EN_TINT]) ch_lo = 8'(mix(ch_lo, ch_hi, a));
        case (ch)
          0: r.red = ch_lo;
          1: r.green = ch_lo;
          2: r.blue = ch_lo;
          default: r.alpha = ch_lo;
        endcase
      end
      r.expired = (r.age >= p.life);
      pending = {pending, r};
    endfunction

    function void field(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        errors++;
        $display("%0t %s mismatch: expected %h, got %h", $time, name, e, g);
      end
    endfunction

    function void check(update_t g);
      update_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected update: expected none, got pos_x %h", $time, g.pos_x);
        return;
      end
      e = pending.pop_front();
      field("new_pos_x", e.pos_x, g.pos_x);
      field("new_pos_y", e.pos_y, g.pos_y);
      field("new_rotation", e.rot, g.rot);
      field("new_age", e.age, g.age);
      field("scale_x", e.scale_x, g.scale_x);
      field("scale_y", e.scale_y, g.scale_y);
      field("tint_red", e.red, g.red);
      field("tint_green", e.green, g.green);
      field("tint_blue", e.blue, g.blue);
      field("tint_alpha", e.alpha, g.alpha);
      field("expired", e.expired, g.expired);
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0, busy;
  logic [31:0] in_pos_x = 0, in_pos_y = 0, in_rotation_deg = 0;
  logic [31:0] in_vel_x = 0, in_vel_y = 0, in_angular_vel = 0;
  logic [30:0] in_age = 0, in_lifetime = 0, in_time_step = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [IdxW-1:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;
  logic out_valid, out_expired;
  logic [31:0] out_new_pos_x, out_new_pos_y, out_new_rotation, out_scale_x, out_scale_y;
  logic [30:0] out_new_age;
  logic [7:0] out_tint_red, out_tint_green, out_tint_blue, out_tint_alpha;

  particle_scoreboard board = new();
  int idle_pct;
  int quiet_cycles;

  particle_state_update_unit DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Monitor: note accepted requests and config writes, check results, watch for a hang
  always @(posedge clk) begin
    update_t g;
    particle_t p;
    if (rst_n) begin
      quiet_cycles++;
      if (start && !busy) begin
        p = '{in_pos_x, in_pos_y, in_rotation_deg, in_vel_x, in_vel_y, in_angular_vel,
              in_age, in_lifetime, in_time_step};
        board.note(p);
        quiet_cycles = 0;
      end
      if (cfg_valid && cfg_ready) begin
        board.write_reg(cfg_index, cfg_wdata);
        quiet_cycles = 0;
      end
      if (out_valid) begin
        g = '{out_new_pos_x, out_new_pos_y, out_new_rotation, out_new_age, out_scale_x,
              out_scale_y, out_tint_red, out_tint_green, out_tint_blue, out_tint_alpha,
              out_expired};
        board.check(g);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [IdxW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1; cfg_index = idx; cfg_wdata = val;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Drive one request from a falling edge, then leave a random gap per the idle rate
  task automatic send(particle_t p);
    {in_pos_x, in_pos_y, in_rotation_deg} = {p.pos_x, p.pos_y, p.rot};
    {in_vel_x, in_vel_y, in_angular_vel} = {p.vel_x, p.vel_y, p.ang};
    {in_age, in_lifetime, in_time_step} = {p.age, p.life, p.step};
    start = 1;
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 0;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
  endtask

  // Pause until every pending update has come out
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PipeLatency + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] any32();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(8)) - 4);
      3: return 32'($signed($urandom) >>> 12);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] any31();
    case ($urandom_range(7))
      0: return AgeMax;
      1: return 0;
      2: return 31'($urandom_range(65536 * 4));
      3: return AgeMax - 31'($urandom_range(65536));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic particle_t any_particle();
    particle_t p;
    p = '{any32(), any32(), any32(), any32(), any32(), any32(), any31(), any31(), any31()};
    // Mostly realistic frames: small step, age around lifetime
    if ($urandom_range(3) != 0) begin
      p.step = 31'($urandom_range(65536));
      p.life = 31'($urandom_range(65536 * 64));
      p.age = 31'($urandom_range(65536 * 70));
    end
    return p;
  endfunction

  task automatic program_phase(int ph);
    logic [31:0] v[7];
    case (ph)
      1: v = '{32'hf, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, '1};
      2: v = '{32'h0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      3: v = '{32'hf, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, '1, 0};
      default: v = '{32'($urandom_range(15)) | ($urandom & 32'hfffffff0), any32(), any32(),
                     any32(), any32(), $urandom, $urandom};
    endcase
    for (int i = 0; i < 7; i++) cfg_write(IdxW'(i), v[i]);
    if (ph == 2) cfg_write(REG_UNMAPPED, 32'hffffffff);
  endtask

  initial begin
    particle_t p;
    board.reset_regs();
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: field extremes, zero lifetime, age saturation, floor rounding, wraps
    send('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send('{'1, '1, '1, '1, '1, '1, AgeMax, AgeMax, AgeMax});
    send('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
           32'h7fffffff, 0, 0, AgeMax});
    send('{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
           32'h80000000, 5, 0, 0});
    send('{1, 2, 3, 32'hffffffff, 32'hfffffffe, 32'hffffffff, 100, 200, 1});
    send('{0, 0, 0, 32'h00010000, 32'hffff0000, 32'h00b40000, 32'h8000, 32'h10000, 32'h8000});
    send('{0, 0, 0, 0, 0, 0, AgeMax - 3, 31'h10000, 10});
    send('{0, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 0});
    send('{0, 0, 0, 0, 0, 0, 31'hffff, 31'h10000, 0});
    send('{0, 0, 0, 0, 0, 0, 0, 1, 0});
    send('{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1, AgeMax, 0});
    for (int ph = 1; ph <= 3; ph++) begin
      drain();
      program_phase(ph);
      for (int i = 0; i < 4; i++) send(any_particle());
      send('{0, 0, 0, 0, 0, 0, 31'h4000, 31'h10000, 31'h4000});
    end

    // Random phases with shifting idle rates
    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain();
      program_phase(ph < 3 ? ph + 1 : 0);
      case (ph % 4)
        1: idle_pct = 83;
        3: idle_pct = 35;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        p = any_particle();
        send(p);
      end
    end

    drain();
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
